// ===== src/stl_pkg.sv =====
package stl_pkg;

  localparam int TableDepthDef = 16;
  localparam int IdBitsDef = 8;
  localparam int FuncW = 3;
  localparam int StatusW = 2;
  localparam int SecW = 32;
  localparam int UsecW = 20;
  localparam int CountW = 5;
  localparam logic [UsecW-1:0] UsecPerSec = 20'd1000000;

  localparam logic [FuncW-1:0] FUNC_INSERT   = 3'd0;
  localparam logic [FuncW-1:0] FUNC_RESCAN   = 3'd1;
  localparam logic [FuncW-1:0] FUNC_GET_EXP  = 3'd2;
  localparam logic [FuncW-1:0] FUNC_GET_HEAD = 3'd3;
  localparam logic [FuncW-1:0] FUNC_REMOVE   = 3'd4;

  localparam logic [StatusW-1:0] ST_OK       = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL     = 2'd1;
  localparam logic [StatusW-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [StatusW-1:0] ST_BADTIME  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SHIFT, S_WRITE, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    SCAN_NONE, SCAN_MATCH, SCAN_END
  } scan_res_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // latch input item, start walk at zero
    logic step;       // process current index, advance
    logic shift;      // move entries during insert or remove
    logic write;      // place new entry, or shrink the count on remove
    logic finish;     // register result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic      shift_needed;
    logic      shift_last;
    logic      direct_done;
    scan_res_t scan;
  } stat_t;

endpackage

// ===== src/sorted_timeout_list.sv =====
// sequence: load, entry walk, entry shift and write for insert or remove, then result held until taken
// flow: one item at a time, the next taken the cycle after the result is taken;
//   the entry walk and the entry shift handle one table entry per cycle
// reset: synchronous active-low rst_n empties the table; entry contents stay undefined
module sorted_timeout_list #(
  parameter int TABLE_DEPTH = stl_pkg::TableDepthDef,
  parameter int ID_BITS = stl_pkg::IdBitsDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [stl_pkg::FuncW-1:0]    in_func,
  input  logic [7:0]                   in_timer_id,
  input  logic                         in_infinite,
  input  logic [stl_pkg::SecW-1:0]     in_timeout_sec,
  input  logic [stl_pkg::UsecW-1:0]    in_timeout_usec,
  input  logic [stl_pkg::SecW-1:0]     in_now_sec,
  input  logic [stl_pkg::UsecW-1:0]    in_now_usec,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [stl_pkg::StatusW-1:0]  out_status,
  output logic                         out_found,
  output logic [7:0]                   out_result_id,
  output logic                         out_result_infinite,
  output logic [stl_pkg::SecW-1:0]     out_left_sec,
  output logic [stl_pkg::UsecW-1:0]    out_left_usec,
  output logic [stl_pkg::CountW-1:0]   out_expired_count
);
  import stl_pkg::*;

  cmd_t  cmd;
  stat_t st;

  stl_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .st, .cmd
  );

  stl_dp #(.TABLE_DEPTH(TABLE_DEPTH), .ID_BITS(ID_BITS)) u_dp (
    .clk, .rst_n, .cmd, .st,
    .in_func, .in_timer_id, .in_infinite, .in_timeout_sec, .in_timeout_usec,
    .in_now_sec, .in_now_usec,
    .out_status, .out_found, .out_result_id, .out_result_infinite,
    .out_left_sec, .out_left_usec, .out_expired_count
  );
endmodule

// ===== src/stl_ctrl.sv =====
module stl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  stl_pkg::stat_t st,
  output stl_pkg::cmd_t  cmd
);
  import stl_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_SCAN;
      S_SCAN: begin
        if (st.direct_done) state_nxt = S_DONE;
        else if (st.scan != SCAN_NONE) begin
          state_nxt = st.shift_needed ? S_SHIFT : S_WRITE;
        end
      end
      S_SHIFT: if (st.shift_last) state_nxt = S_WRITE;
      S_WRITE: state_nxt = S_DONE;
      S_DONE:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SCAN:  cmd.step = 1'b1;
      S_SHIFT: cmd.shift = 1'b1;
      S_WRITE: cmd.write = 1'b1;
      S_DONE:  out_valid = 1'b1;
      default: ;
    endcase
    cmd.finish = (state_r == S_SCAN && st.direct_done) || state_r == S_WRITE;
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |=> out_valid) else $error("write not followed by result");
`endif
endmodule

// ===== src/stl_dp.sv =====
module stl_dp #(
  parameter int TABLE_DEPTH = stl_pkg::TableDepthDef,
  parameter int ID_BITS = stl_pkg::IdBitsDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  stl_pkg::cmd_t                cmd,
  output stl_pkg::stat_t               st,
  input  logic [stl_pkg::FuncW-1:0]    in_func,
  input  logic [7:0]                   in_timer_id,
  input  logic                         in_infinite,
  input  logic [stl_pkg::SecW-1:0]     in_timeout_sec,
  input  logic [stl_pkg::UsecW-1:0]    in_timeout_usec,
  input  logic [stl_pkg::SecW-1:0]     in_now_sec,
  input  logic [stl_pkg::UsecW-1:0]    in_now_usec,
  output logic [stl_pkg::StatusW-1:0]  out_status,
  output logic                         out_found,
  output logic [7:0]                   out_result_id,
  output logic                         out_result_infinite,
  output logic [stl_pkg::SecW-1:0]     out_left_sec,
  output logic [stl_pkg::UsecW-1:0]    out_left_usec,
  output logic [stl_pkg::CountW-1:0]   out_expired_count
);
  import stl_pkg::*;

  localparam int IdxW = $clog2(TABLE_DEPTH);
  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam int DepW = CntW + 1;

  logic [ID_BITS-1:0] id_m [TABLE_DEPTH];
  logic               inf_m [TABLE_DEPTH];
  logic [SecW-1:0]    exs_m [TABLE_DEPTH];
  logic [UsecW-1:0]   exu_m [TABLE_DEPTH];
  logic [SecW-1:0]    lfs_m [TABLE_DEPTH];
  logic [UsecW-1:0]   lfu_m [TABLE_DEPTH];

  logic [CntW-1:0]  count_r;
  logic [CntW-1:0]  idx_r;
  logic [CntW-1:0]  pos_r;
  logic [CntW-1:0]  sh_r;
  logic [FuncW-1:0] func_r;
  logic [ID_BITS-1:0] id_r;
  logic             inf_r;
  logic [SecW-1:0]  ts_r, ns_r;
  logic [UsecW-1:0] tu_r, nu_r;
  logic [CountW-1:0] exp_r;

  logic [IdxW-1:0] ix, sx;
  assign ix = idx_r[IdxW-1:0];
  assign sx = sh_r[IdxW-1:0];

  logic at_end, badt, full_c, hit;
  logic [SecW:0]    ds;
  logic [UsecW:0]   du;
  logic [SecW-1:0]  ls_n;
  logic [UsecW-1:0] lu_n;
  logic [UsecW:0]   eu;
  logic [UsecW-1:0] eu_fix;
  logic             ecar;

  assign at_end = idx_r >= count_r;
  assign full_c = count_r == CntW'(TABLE_DEPTH);
  assign badt = (func_r == FUNC_INSERT && !inf_r && (tu_r >= UsecPerSec || nu_r >= UsecPerSec))
             || (func_r == FUNC_RESCAN && nu_r >= UsecPerSec);

  // rescan arithmetic on current entry
  always_comb begin
    du = {1'b0, exu_m[ix]} - {1'b0, nu_r};
    ds = {1'b0, exs_m[ix]} - {1'b0, ns_r};
    if (du[UsecW]) begin
      du = du + {1'b0, UsecPerSec};
      ds = ds - 1'b1;
    end
    if (ds[SecW]) begin
      ls_n = '0;
      lu_n = '0;
    end else begin
      ls_n = ds[SecW-1:0];
      lu_n = du[UsecW-1:0];
    end
  end

  always_comb begin
    hit = 1'b0;
    case (func_r)
      FUNC_INSERT:  hit = !inf_r && (inf_m[ix] || lfs_m[ix] > ts_r ||
                          (lfs_m[ix] == ts_r && lfu_m[ix] > tu_r));
      FUNC_GET_EXP: hit = !inf_m[ix] && lfs_m[ix] == '0 && lfu_m[ix] == '0;
      FUNC_REMOVE:  hit = id_m[ix] == id_r;
      default:      hit = 1'b0;
    endcase
  end

  always_comb begin
    st = '0;
    if (!at_end && hit) st.scan = SCAN_MATCH;
    else if (at_end) st.scan = SCAN_END;
    else st.scan = SCAN_NONE;
    case (func_r)
      FUNC_INSERT:   st.direct_done = badt || full_c;
      FUNC_RESCAN:   st.direct_done = badt || at_end;
      FUNC_GET_EXP:  st.direct_done = at_end || hit;
      FUNC_GET_HEAD: st.direct_done = 1'b1;
      FUNC_REMOVE:   st.direct_done = at_end;
      default:       st.direct_done = 1'b1;
    endcase
    if (func_r == FUNC_INSERT) begin
      st.shift_needed = count_r > (at_end ? count_r : idx_r);
      st.shift_last = sh_r == pos_r + 1'b1;
    end else begin
      st.shift_needed = 1'b1;
      st.shift_last = DepW'(sh_r) + 1'b1 >= DepW'(count_r) - 1'b1;
    end
  end

  always_comb begin
    eu = {1'b0, nu_r} + {1'b0, tu_r};
    ecar = eu >= {1'b0, UsecPerSec};
    eu_fix = ecar ? UsecW'(eu - {1'b0, UsecPerSec}) : eu[UsecW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      if (cmd.write) begin
        if (func_r == FUNC_INSERT) count_r <= count_r + 1'b1;
        else count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      id_r <= ID_BITS'(in_timer_id);
      inf_r <= in_infinite;
      ts_r <= in_timeout_sec;
      tu_r <= in_timeout_usec;
      ns_r <= in_now_sec;
      nu_r <= in_now_usec;
      idx_r <= '0;
      exp_r <= '0;
    end
    if (cmd.step) begin
      if (func_r == FUNC_RESCAN && !at_end && !badt && !inf_m[ix]) begin
        lfs_m[ix] <= ls_n;
        lfu_m[ix] <= lu_n;
        if (ls_n == '0 && lu_n == '0 && exp_r != '1) exp_r <= exp_r + 1'b1;
      end
      if (st.scan == SCAN_NONE) idx_r <= idx_r + 1'b1;
      pos_r <= at_end ? count_r : idx_r;
      sh_r <= (func_r == FUNC_INSERT) ? count_r : idx_r;
    end
    if (cmd.shift) begin
      if (func_r == FUNC_INSERT) begin
        id_m[sx] <= id_m[sx-1'b1];   inf_m[sx] <= inf_m[sx-1'b1];
        exs_m[sx] <= exs_m[sx-1'b1]; exu_m[sx] <= exu_m[sx-1'b1];
        lfs_m[sx] <= lfs_m[sx-1'b1]; lfu_m[sx] <= lfu_m[sx-1'b1];
        sh_r <= sh_r - 1'b1;
      end else begin
        if (DepW'(sh_r) + 1'b1 < DepW'(count_r)) begin
          id_m[sx] <= id_m[sx+1'b1];   inf_m[sx] <= inf_m[sx+1'b1];
          exs_m[sx] <= exs_m[sx+1'b1]; exu_m[sx] <= exu_m[sx+1'b1];
          lfs_m[sx] <= lfs_m[sx+1'b1]; lfu_m[sx] <= lfu_m[sx+1'b1];
        end
        sh_r <= sh_r + 1'b1;
      end
    end
    if (cmd.write && func_r == FUNC_INSERT) begin
      id_m[pos_r[IdxW-1:0]] <= id_r;
      inf_m[pos_r[IdxW-1:0]] <= inf_r;
      exs_m[pos_r[IdxW-1:0]] <= inf_r ? '0 : ns_r + ts_r + SecW'(ecar);
      exu_m[pos_r[IdxW-1:0]] <= inf_r ? '0 : eu_fix;
      lfs_m[pos_r[IdxW-1:0]] <= inf_r ? '0 : ts_r;
      lfu_m[pos_r[IdxW-1:0]] <= inf_r ? '0 : tu_r;
    end
    if (cmd.finish) begin
      out_status <= ST_OK;
      out_found <= 1'b0;
      out_result_id <= '0;
      out_result_infinite <= 1'b0;
      out_left_sec <= '0;
      out_left_usec <= '0;
      out_expired_count <= '0;
      case (func_r)
        FUNC_INSERT: begin
          if (badt) out_status <= ST_BADTIME;
          else if (full_c) out_status <= ST_FULL;
        end
        FUNC_RESCAN: begin
          if (badt) out_status <= ST_BADTIME;
          else out_expired_count <= exp_r;
        end
        FUNC_GET_EXP, FUNC_GET_HEAD: begin
          if ((func_r == FUNC_GET_EXP) ? (at_end || !hit) : (count_r == '0)) begin
            out_status <= ST_NOTFOUND;
          end else begin
            out_found <= 1'b1;
            out_result_id <= 8'(id_m[ix]);
            out_result_infinite <= inf_m[ix];
            out_left_sec <= lfs_m[ix];
            out_left_usec <= lfu_m[ix];
          end
        end
        FUNC_REMOVE: if (!cmd.write) out_status <= ST_NOTFOUND;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(TABLE_DEPTH)) else $error("count over depth");
  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write && func_r == FUNC_INSERT |=> count_r == $past(count_r) + 1'b1)
    else $error("insert count");
  a_rem_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write && func_r == FUNC_REMOVE |-> count_r != '0) else $error("remove on empty");
`endif
endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import stl_pkg::*;

  localparam int Depth = 16;
  localparam int MaxCycles = 400000;
  localparam int MaxErrShown = 10;

  typedef struct packed {
    logic [FuncW-1:0]   func;
    logic [7:0]         timer_id;
    logic               infinite;
    logic [SecW-1:0]    timeout_sec;
    logic [UsecW-1:0]   timeout_usec;
    logic [SecW-1:0]    now_sec;
    logic [UsecW-1:0]   now_usec;
  } timer_req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               found;
    logic [7:0]         result_id;
    logic               result_infinite;
    logic [SecW-1:0]    left_sec;
    logic [UsecW-1:0]   left_usec;
    logic [CountW-1:0]  expired_count;
  } timer_resp_t;

  typedef struct {
    timer_req_t  req;
    logic        typed;
    timer_resp_t resp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  timer_req_t req_drv = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  timer_resp_t resp_seen;

  always #2 clk = ~clk;

  sorted_timeout_list i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (req_drv.func),
    .in_timer_id         (req_drv.timer_id),
    .in_infinite         (req_drv.infinite),
    .in_timeout_sec      (req_drv.timeout_sec),
    .in_timeout_usec     (req_drv.timeout_usec),
    .in_now_sec          (req_drv.now_sec),
    .in_now_usec         (req_drv.now_usec),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (resp_seen.status),
    .out_found           (resp_seen.found),
    .out_result_id       (resp_seen.result_id),
    .out_result_infinite (resp_seen.result_infinite),
    .out_left_sec        (resp_seen.left_sec),
    .out_left_usec       (resp_seen.left_usec),
    .out_expired_count   (resp_seen.expired_count)
  );

  // timer table mirror
  logic [7:0]       tbl_id [Depth];
  logic             tbl_inf [Depth];
  logic [SecW-1:0]  tbl_exp_sec [Depth];
  logic [UsecW-1:0] tbl_exp_usec [Depth];
  logic [SecW-1:0]  tbl_left_sec [Depth];
  logic [UsecW-1:0] tbl_left_usec [Depth];
  int               tbl_count = 0;

  timer_resp_t pending_resp[$];
  int  mismatches = 0;
  int  items_sent = 0;
  int  resp_checked = 0;
  int  expired_hits = 0;
  int  full_hits = 0;
  longint cycle_count = 0;

  function automatic void move_entry(int dst, int src);
    tbl_id[dst] = tbl_id[src];
    tbl_inf[dst] = tbl_inf[src];
    tbl_exp_sec[dst] = tbl_exp_sec[src];
    tbl_exp_usec[dst] = tbl_exp_usec[src];
    tbl_left_sec[dst] = tbl_left_sec[src];
    tbl_left_usec[dst] = tbl_left_usec[src];
  endfunction

  function automatic timer_resp_t apply_timer_op(timer_req_t r);
    timer_resp_t res;
    int pos;
    int nexp;
    logic [UsecW:0] usum;
    logic carry;
    longint ds;
    longint du;
    res = '0;
    case (r.func)
      FUNC_INSERT: begin
        if (!r.infinite && (r.timeout_usec >= UsecPerSec || r.now_usec >= UsecPerSec)) begin
          res.status = ST_BADTIME;
        end else if (tbl_count >= Depth) begin
          res.status = ST_FULL;
        end else begin
          pos = tbl_count;
          if (!r.infinite) begin
            for (int i = 0; i < tbl_count; i++) begin
              if (tbl_inf[i] || tbl_left_sec[i] > r.timeout_sec ||
                  (tbl_left_sec[i] == r.timeout_sec && tbl_left_usec[i] > r.timeout_usec)) begin
                pos = i;
                break;
              end
            end
          end
          for (int i = tbl_count; i > pos; i--) move_entry(i, i - 1);
          tbl_id[pos] = r.timer_id;
          tbl_inf[pos] = r.infinite;
          if (r.infinite) begin
            tbl_exp_sec[pos] = '0;
            tbl_exp_usec[pos] = '0;
            tbl_left_sec[pos] = '0;
            tbl_left_usec[pos] = '0;
          end else begin
            usum = r.now_usec + r.timeout_usec;
            carry = usum >= UsecPerSec;
            if (carry) usum = usum - UsecPerSec;
            tbl_exp_sec[pos] = r.now_sec + r.timeout_sec + carry;
            tbl_exp_usec[pos] = usum[UsecW-1:0];
            tbl_left_sec[pos] = r.timeout_sec;
            tbl_left_usec[pos] = r.timeout_usec;
          end
          tbl_count++;
        end
      end
      FUNC_RESCAN: begin
        if (r.now_usec >= UsecPerSec) begin
          res.status = ST_BADTIME;
        end else begin
          nexp = 0;
          for (int i = 0; i < tbl_count; i++) begin
            if (tbl_inf[i]) continue;
            ds = longint'(tbl_exp_sec[i]) - longint'(r.now_sec);
            du = longint'(tbl_exp_usec[i]) - longint'(r.now_usec);
            if (du < 0) begin
              du += 1000000;
              ds -= 1;
            end
            if (ds < 0) begin
              tbl_left_sec[i] = '0;
              tbl_left_usec[i] = '0;
            end else begin
              tbl_left_sec[i] = ds[SecW-1:0];
              tbl_left_usec[i] = du[UsecW-1:0];
            end
            if (tbl_left_sec[i] == 0 && tbl_left_usec[i] == 0) nexp++;
          end
          res.expired_count = (nexp > 31) ? 5'd31 : nexp[CountW-1:0];
        end
      end
      FUNC_GET_EXP: begin
        res.status = ST_NOTFOUND;
        for (int i = 0; i < tbl_count; i++) begin
          if (!tbl_inf[i] && tbl_left_sec[i] == 0 && tbl_left_usec[i] == 0) begin
            res.status = ST_OK;
            res.found = 1'b1;
            res.result_id = tbl_id[i];
            res.result_infinite = tbl_inf[i];
            res.left_sec = tbl_left_sec[i];
            res.left_usec = tbl_left_usec[i];
            break;
          end
        end
      end
      FUNC_GET_HEAD: begin
        if (tbl_count == 0) begin
          res.status = ST_NOTFOUND;
        end else begin
          res.found = 1'b1;
          res.result_id = tbl_id[0];
          res.result_infinite = tbl_inf[0];
          res.left_sec = tbl_left_sec[0];
          res.left_usec = tbl_left_usec[0];
        end
      end
      FUNC_REMOVE: begin
        res.status = ST_NOTFOUND;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_id[i] == r.timer_id) begin
            for (int j = i; j + 1 < tbl_count; j++) move_entry(j, j + 1);
            tbl_count--;
            res.status = ST_OK;
            break;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic timer_req_t make_req(logic [FuncW-1:0] f, logic [7:0] id, logic inf,
                                          logic [SecW-1:0] ts, logic [UsecW-1:0] tu,
                                          logic [SecW-1:0] ns, logic [UsecW-1:0] nu);
    timer_req_t r;
    r.func = f;
    r.timer_id = id;
    r.infinite = inf;
    r.timeout_sec = ts;
    r.timeout_usec = tu;
    r.now_sec = ns;
    r.now_usec = nu;
    return r;
  endfunction

  task automatic send_item(timer_req_t r);
    timer_resp_t exp_resp;
    int stall;
    stall = $urandom_range(0, 5);
    if (stall != 0) begin
      in_valid <= 1'b0;
      repeat (stall) @(posedge clk);
    end
    req_drv <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    exp_resp = apply_timer_op(r);
    if (exp_resp.status == ST_FULL) full_hits++;
    if (r.func == FUNC_GET_EXP && exp_resp.found) expired_hits++;
    pending_resp.push_back(exp_resp);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_resp.size() != 0) @(posedge clk);
  endtask

  // result side: random stall per item
  initial begin
    int stall;
    timer_resp_t want;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, 5);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pending_resp.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxErrShown) $display("unexpected result item %p", resp_seen);
      end else begin
        want = pending_resp.pop_front();
        resp_checked++;
        if (resp_seen !== want) begin
          mismatches++;
          if (mismatches <= MaxErrShown)
            $display("mismatch: expected %p got %p", want, resp_seen);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycles) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    timer_req_t r;
    int roll;
    logic [31:0] now_s;
    logic [19:0] now_u;
    logic [31:0] now_acc;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    rows.push_back('{make_req(FUNC_GET_HEAD, 0, 0, 0, 0, 0, 0), 1, '{ST_NOTFOUND, 0, 0, 0, 0, 0, 0}});
    rows.push_back('{make_req(FUNC_GET_EXP, 0, 0, 0, 0, 0, 0), 1, '{ST_NOTFOUND, 0, 0, 0, 0, 0, 0}});
    rows.push_back('{make_req(FUNC_REMOVE, 8'h55, 0, 0, 0, 0, 0), 1, '{ST_NOTFOUND, 0, 0, 0, 0, 0, 0}});
    rows.push_back('{make_req(FUNC_INSERT, 1, 0, 5, 20'hFFFFF, 0, 0), 1, '{ST_BADTIME, 0, 0, 0, 0, 0, 0}});
    rows.push_back('{make_req(FUNC_INSERT, 1, 0, 5, 0, 0, 1000000), 1, '{ST_BADTIME, 0, 0, 0, 0, 0, 0}});
    rows.push_back('{make_req(FUNC_RESCAN, 0, 0, 0, 0, 0, 20'hFFFFF), 1, '{ST_BADTIME, 0, 0, 0, 0, 0, 0}});
    rows.push_back('{make_req(FUNC_INSERT, 8'hFF, 1, 32'hFFFFFFFF, 20'hFFFFF, 1, 20'hFFFFF), 0, '0});
    rows.push_back('{make_req(FUNC_INSERT, 8'h10, 0, 32'hFFFFFFFF, 999999, 32'hFFFFFFFF, 999999), 0, '0});
    rows.push_back('{make_req(FUNC_INSERT, 8'h00, 0, 0, 0, 100, 0), 0, '0});
    rows.push_back('{make_req(FUNC_INSERT, 8'h20, 0, 3, 500000, 100, 600000), 0, '0});
    rows.push_back('{make_req(FUNC_INSERT, 8'h20, 0, 3, 500000, 100, 0), 0, '0});
    rows.push_back('{make_req(FUNC_GET_HEAD, 0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{make_req(FUNC_GET_EXP, 0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{make_req(FUNC_RESCAN, 0, 0, 0, 0, 104, 100000), 0, '0});
    rows.push_back('{make_req(FUNC_GET_EXP, 0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{make_req(FUNC_RESCAN, 0, 0, 0, 0, 32'hFFFFFFFF, 999999), 0, '0});
    rows.push_back('{make_req(FUNC_REMOVE, 8'h20, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{make_req(5, 8'hAA, 1, 32'h1234, 7, 9, 9), 1, '0});
    rows.push_back('{make_req(7, 8'h55, 0, 0, 0, 0, 0), 1, '0});
    foreach (rows[k]) begin
      send_item(rows[k].req);
      if (rows[k].typed) pending_resp[$] = rows[k].resp;
    end
    // fill to overflow: the last inserts find the table full
    for (int k = 0; k < Depth; k++)
      send_item(make_req(FUNC_INSERT, k[7:0], k[0], k, 0, 50, 0));
    drain_results();
    for (int k = 0; k < Depth + 2; k++) send_item(make_req(FUNC_REMOVE, k[7:0], 0, 0, 0, 0, 0));
    for (int k = 0; k < 4; k++) send_item(make_req(FUNC_REMOVE, 8'hFF, 0, 0, 0, 0, 0));
    drain_results();

    // random part: mostly well-formed timer traffic on a slowly moving clock
    now_s = $urandom_range(0, 1000);
    now_u = 20'($urandom_range(0, 999999));
    for (int k = 0; k < 1300; k++) begin
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 7) == 0) begin
        now_acc = now_u + $urandom_range(0, 999999);
        if (now_acc >= 1000000) begin
          now_acc = now_acc - 1000000;
          now_s++;
        end
        now_u = now_acc[19:0];
        now_s = now_s + $urandom_range(0, 3);
      end
      r = make_req(FUNC_INSERT, 8'($urandom_range(0, 15)), $urandom_range(0, 9) == 0,
                   $urandom_range(0, 4), 20'($urandom_range(0, 999999)), now_s, now_u);
      if ($urandom_range(0, 9) == 0) r.timer_id = 8'($urandom());
      if (roll < 35) begin
        if ($urandom_range(0, 19) == 0) r.timeout_sec = $urandom();
        if ($urandom_range(0, 19) == 0) r.timeout_usec = 20'($urandom());
        if ($urandom_range(0, 29) == 0) r.now_usec = 20'($urandom());
        if ($urandom_range(0, 29) == 0) r.now_sec = $urandom();
      end else if (roll < 55) begin
        r.func = FUNC_RESCAN;
        if ($urandom_range(0, 29) == 0) r.now_usec = 20'($urandom());
      end else if (roll < 70) begin
        r.func = FUNC_GET_EXP;
      end else if (roll < 80) begin
        r.func = FUNC_GET_HEAD;
      end else if (roll < 96) begin
        r.func = FUNC_REMOVE;
      end else begin
        r.func = 3'($urandom());
        r.timer_id = 8'($urandom());
        r.infinite = 1'($urandom());
        r.timeout_sec = $urandom();
        r.now_sec = $urandom();
        r.timeout_usec = 20'($urandom());
        r.now_usec = 20'($urandom());
      end
      send_item(r);
      if (k == 650) drain_results();
    end

    drain_results();
    repeat (60) @(posedge clk);
    $display("%0d items sent, %0d results checked", items_sent, resp_checked);
    $display("expired entries returned %0d times, full table hit %0d times",
             expired_hits, full_hits);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sorted_timeout_list.f =====
src/stl_pkg.sv
src/stl_ctrl.sv
src/stl_dp.sv
src/sorted_timeout_list.sv
verif/testbench.sv
